// ----- hdl/array_linked_list_manager_core_defines.svh -----
// Assertion macros of the linked list manager core.
`ifndef ARRAY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante (uses clk and rst_n of the caller).
`define ALM_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ALM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/alm_pkg.sv -----
// Types and constants of the array linked list manager.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

    // Widths fixed by the request and response formats
    localparam int OP_BITS       = 3;
    localparam int VALUE_BITS    = 32;
    localparam int STATUS_BITS   = 2;
    localparam int MAX_DATA_BITS = 64;

    typedef enum logic [OP_BITS-1:0] {
        OP_FRONT  = 3'd0,
        OP_BACK   = 3'd1,
        OP_AFTER  = 3'd2,
        OP_BEFORE = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FIRST,
        ACT_FRONT,
        ACT_BACK,
        ACT_BETWEEN,
        ACT_DELETE
    } act_t;

    // Write strobes into the slot store
    typedef struct packed {
        logic next_we;
        logic link_we;
        logic data_we;
    } store_we_t;

endpackage

`default_nettype wire

// ----- hdl/alm_if.sv -----
// Request and response channel interfaces of the linked list manager.
`timescale 1ns / 1ps
`default_nettype none

interface alm_req_if #(
    parameter int SLOT_BITS = 7
);
    logic                             valid;
    logic                             ready;
    logic [alm_pkg::OP_BITS-1:0]      operation;
    logic [alm_pkg::VALUE_BITS-1:0]   value;
    logic [SLOT_BITS-1:0]             position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface alm_rsp_if #(
    parameter int SLOT_BITS = 7
);
    logic                             valid;
    logic                             ready;
    logic [SLOT_BITS-1:0]             slot;
    logic [alm_pkg::STATUS_BITS-1:0]  status;
    logic [SLOT_BITS-1:0]             count;

    modport source (output valid, output slot, output status, output count,
                    input ready);
    modport sink   (input valid, input slot, input status, input count,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/array_linked_list_manager_core.sv -----
// Top level of the array linked list manager: sequencer, list registers, result register.
//
// Usage:
//   req carries one operation (insert front, back, after or before a slot, or delete a
//   slot) with a value and a position; rsp returns the slot used, a status and the
//   element count after the operation. Both channels move a request when valid and
//   ready are high at a rising clock edge.
//   Each request passes through acceptance and link read (idle), decide and first write
//   (exec), then second write and result load (finish). The link store has one write port
//   per memory, which is why the writes are split in two. One request is in flight at a
//   time; rsp.valid rises and req.ready returns in the same cycle.
//   After reset the block sweeps the link memories to build the free chain, with
//   req.ready low until the sweep ends. Slot data stays undefined until written.
//   A stalled rsp holds its result; the next request is still accepted and worked up to
//   its result load, which waits until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "array_linked_list_manager_core_defines.svh"

module array_linked_list_manager_core #(
    parameter int CAPACITY  = 64,
    parameter int DATA_BITS = 32
) (
    input  wire       clk,
    input  wire       rst_n,
    alm_req_if.sink   req,
    alm_rsp_if.source rsp
);

    localparam int NSLOTS    = CAPACITY + 1;
    localparam int SLOT_BITS = $clog2(NSLOTS);
    localparam int WideBits  = alm_pkg::MAX_DATA_BITS;
    localparam logic [SLOT_BITS-1:0] CAP_W = SLOT_BITS'(CAPACITY);

    // Sequencer and list registers
    alm_pkg::state_t      state_reg, state_next;
    logic [SLOT_BITS-1:0] init_cnt_reg, init_cnt_next;
    logic [SLOT_BITS-1:0] head_reg, head_next;
    logic [SLOT_BITS-1:0] tail_reg, tail_next;
    logic [SLOT_BITS-1:0] free_reg, free_next;
    logic [SLOT_BITS-1:0] count_reg, count_next;

    // Captured request
    alm_pkg::op_t                   op_reg;
    logic [alm_pkg::VALUE_BITS-1:0] value_reg;
    logic [SLOT_BITS-1:0]           pos_reg;

    // Second write, planned in the decide cycle
    logic                 w2n_we_reg, w2n_we_next;
    logic [SLOT_BITS-1:0] w2n_addr_reg, w2n_addr_next;
    logic [SLOT_BITS-1:0] w2n_data_reg, w2n_data_next;
    logic                 w2l_we_reg, w2l_we_next;
    logic [SLOT_BITS-1:0] w2l_addr_reg, w2l_addr_next;
    logic [SLOT_BITS:0]   w2l_data_reg, w2l_data_next;

    // Pending and delivered result
    logic [SLOT_BITS-1:0]   res_slot_reg, res_slot_next;
    alm_pkg::status_t       res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0]   out_slot_reg;
    alm_pkg::status_t       out_status_reg;
    logic [SLOT_BITS-1:0]   out_count_reg;
    logic                   out_load;

    // First write, straight from the decision
    alm_pkg::act_t        act;
    logic [SLOT_BITS-1:0] w1_slot;
    logic [SLOT_BITS-1:0] w1_next;
    logic [SLOT_BITS:0]   w1_link;

    // Store ports
    alm_pkg::store_we_t   st_we;
    logic [SLOT_BITS-1:0] st_next_waddr, st_next_wdata;
    logic [SLOT_BITS-1:0] st_link_waddr;
    logic [SLOT_BITS:0]   st_link_wdata;
    logic [DATA_BITS-1:0] st_data_wdata;
    logic [SLOT_BITS-1:0] st_pos_raddr;
    logic [SLOT_BITS-1:0] rd_pos_next;
    logic [SLOT_BITS:0]   rd_pos_link;
    logic [SLOT_BITS-1:0] rd_free_next;
    logic [SLOT_BITS-1:0] rd_pos_prev;
    logic                 rd_pos_used;
    logic [WideBits-1:0]  value_wide;
    logic                 req_accept;

    assign req_accept  = req.valid && req.ready;
    assign rd_pos_prev = rd_pos_link[SLOT_BITS-1:0];
    assign rd_pos_used = rd_pos_link[SLOT_BITS];
    assign value_wide  = WideBits'(value_reg);
    assign st_data_wdata = value_wide[DATA_BITS-1:0];
    // Out-of-range positions read slot 0; the result is not used then
    assign st_pos_raddr = (req.position > CAP_W) ? '0 : req.position;

    alm_slot_store #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .clk        (clk),
        .we         (st_we),
        .next_waddr (st_next_waddr),
        .next_wdata (st_next_wdata),
        .link_waddr (st_link_waddr),
        .link_wdata (st_link_wdata),
        .data_waddr (w1_slot),
        .data_wdata (st_data_wdata),
        .pos_raddr  (st_pos_raddr),
        .free_raddr (free_reg),
        .pos_next   (rd_pos_next),
        .pos_link   (rd_pos_link),
        .free_next  (rd_free_next)
    );

    // Classify the request from the links read at acceptance
    always_comb
    begin : decide
        act             = alm_pkg::ACT_NONE;
        res_status_next = alm_pkg::STAT_OK;
        if (op_reg inside {alm_pkg::OP_FRONT, alm_pkg::OP_BACK,
                           alm_pkg::OP_AFTER, alm_pkg::OP_BEFORE})
        begin
            if (count_reg >= CAP_W)
                res_status_next = alm_pkg::STAT_FULL;
            else if (count_reg == '0)
                act = alm_pkg::ACT_FIRST;
            else if (op_reg == alm_pkg::OP_FRONT)
                act = alm_pkg::ACT_FRONT;
            else if (op_reg == alm_pkg::OP_BACK)
                act = alm_pkg::ACT_BACK;
            else if (pos_reg > CAP_W)
                res_status_next = alm_pkg::STAT_RANGE;
            else if (!rd_pos_used)
                res_status_next = alm_pkg::STAT_FREE;
            else if (op_reg == alm_pkg::OP_AFTER)
            begin
                if (pos_reg == tail_reg)
                    act = alm_pkg::ACT_BACK;
                else if (pos_reg == '0)
                    act = alm_pkg::ACT_FRONT;
                else
                    act = alm_pkg::ACT_BETWEEN;
            end
            else
            begin
                if (pos_reg == head_reg)
                    act = alm_pkg::ACT_FRONT;
                else if (pos_reg == '0)
                    act = alm_pkg::ACT_BACK;
                else
                    act = alm_pkg::ACT_BETWEEN;
            end
        end
        else if (op_reg == alm_pkg::OP_DELETE)
        begin
            if (pos_reg > CAP_W || pos_reg == '0)
                res_status_next = alm_pkg::STAT_RANGE;
            else if (!rd_pos_used)
                res_status_next = alm_pkg::STAT_FREE;
            else
                act = alm_pkg::ACT_DELETE;
        end
    end

    // Plan both writes and the list register updates
    always_comb
    begin : plan
        w1_slot       = free_reg;
        w1_next       = '0;
        w1_link       = {1'b1, {SLOT_BITS{1'b0}}};
        w2n_we_next   = 1'b0;
        w2n_addr_next = '0;
        w2n_data_next = free_reg;
        w2l_we_next   = 1'b0;
        w2l_addr_next = '0;
        w2l_data_next = {1'b1, free_reg};
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = rd_free_next;
        count_next    = count_reg + 1'b1;
        res_slot_next = free_reg;
        case (act)
            alm_pkg::ACT_FIRST:
            begin
                head_next = free_reg;
                tail_next = free_reg;
            end
            alm_pkg::ACT_FRONT:
            begin
                // New head points forward to the old head, which points back to it
                w1_next       = head_reg;
                w2l_we_next   = 1'b1;
                w2l_addr_next = head_reg;
                head_next     = free_reg;
            end
            alm_pkg::ACT_BACK:
            begin
                w1_link       = {1'b1, tail_reg};
                w2n_we_next   = 1'b1;
                w2n_addr_next = tail_reg;
                tail_next     = free_reg;
            end
            alm_pkg::ACT_BETWEEN:
            begin
                // Splice between a and b: after takes b = next(pos), before takes a = prev(pos)
                if (op_reg == alm_pkg::OP_AFTER)
                begin
                    w1_next       = rd_pos_next;
                    w1_link       = {1'b1, pos_reg};
                    w2n_addr_next = pos_reg;
                    w2l_addr_next = rd_pos_next;
                end
                else
                begin
                    w1_next       = pos_reg;
                    w1_link       = {1'b1, rd_pos_prev};
                    w2n_addr_next = rd_pos_prev;
                    w2l_addr_next = pos_reg;
                end
                w2n_we_next = 1'b1;
                w2l_we_next = 1'b1;
            end
            alm_pkg::ACT_DELETE:
            begin
                // Free the slot onto the front of the free chain, then bridge its neighbors
                w1_slot       = pos_reg;
                w1_next       = free_reg;
                w1_link       = '0;
                w2n_we_next   = (rd_pos_prev != '0);
                w2n_addr_next = rd_pos_prev;
                w2n_data_next = rd_pos_next;
                w2l_we_next   = (rd_pos_next != '0);
                w2l_addr_next = rd_pos_next;
                w2l_data_next = {1'b1, rd_pos_prev};
                if (rd_pos_prev == '0)
                    head_next = rd_pos_next;
                if (rd_pos_next == '0)
                    tail_next = rd_pos_prev;
                free_next     = pos_reg;
                count_next    = count_reg - 1'b1;
                res_slot_next = pos_reg;
            end
            default:
            begin
                free_next     = free_reg;
                count_next    = count_reg;
                res_slot_next = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin : fsm_next
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        case (state_reg)
            alm_pkg::ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == CAP_W)
                    state_next = alm_pkg::ST_IDLE;
            end
            alm_pkg::ST_IDLE:
            begin
                if (req.valid)
                    state_next = alm_pkg::ST_EXEC;
            end
            alm_pkg::ST_EXEC:
            begin
                state_next = alm_pkg::ST_FINISH;
            end
            alm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = alm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = alm_pkg::ST_INIT;
            end
        endcase
    end

    // Outputs: handshake, store writes, result load
    always_comb
    begin : fsm_out
        req.ready     = 1'b0;
        out_load      = 1'b0;
        st_we         = '0;
        st_next_waddr = w1_slot;
        st_next_wdata = w1_next;
        st_link_waddr = w1_slot;
        st_link_wdata = w1_link;
        case (state_reg)
            alm_pkg::ST_INIT:
            begin
                // Build the free chain: slot i -> i + 1, last slot and sentinel -> 0
                st_we.next_we = 1'b1;
                st_we.link_we = 1'b1;
                st_next_waddr = init_cnt_reg;
                st_link_waddr = init_cnt_reg;
                if (init_cnt_reg == '0 || init_cnt_reg == CAP_W)
                    st_next_wdata = '0;
                else
                    st_next_wdata = init_cnt_reg + 1'b1;
                st_link_wdata = {(init_cnt_reg == '0), {SLOT_BITS{1'b0}}};
            end
            alm_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            alm_pkg::ST_EXEC:
            begin
                st_we.next_we = (act != alm_pkg::ACT_NONE);
                st_we.link_we = (act != alm_pkg::ACT_NONE);
                st_we.data_we = (act != alm_pkg::ACT_NONE) && (act != alm_pkg::ACT_DELETE);
            end
            alm_pkg::ST_FINISH:
            begin
                // Repeating these writes while stalled is harmless
                st_we.next_we = w2n_we_reg;
                st_we.link_we = w2l_we_reg;
                st_next_waddr = w2n_addr_reg;
                st_next_wdata = w2n_data_reg;
                st_link_waddr = w2l_addr_reg;
                st_link_wdata = w2l_data_reg;
                out_load      = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Drop the held result when taken, load a new one when it is free
    always_comb
    begin : out_ctrl
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alm_pkg::ST_INIT;
            init_cnt_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= SLOT_BITS'(1);
            count_reg     <= '0;
            w2n_we_reg    <= 1'b0;
            w2l_we_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == alm_pkg::ST_EXEC)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                free_reg   <= free_next;
                count_reg  <= count_next;
                w2n_we_reg <= w2n_we_next;
                w2l_we_reg <= w2l_we_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg    <= alm_pkg::op_t'(req.operation);
            value_reg <= req.value;
            pos_reg   <= req.position;
        end
        if (state_reg == alm_pkg::ST_EXEC)
        begin
            w2n_addr_reg   <= w2n_addr_next;
            w2n_data_reg   <= w2n_data_next;
            w2l_addr_reg   <= w2l_addr_next;
            w2l_data_reg   <= w2l_data_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
        end
        if (out_load)
        begin
            out_slot_reg   <= res_slot_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.status = out_status_reg;
    assign rsp.count  = out_count_reg;

    `ALM_CHECK_NOW(a_count_bound, 1'b1, count_reg <= CAP_W, "element count above capacity")
    `ALM_CHECK_NOW(a_free_avail, (state_reg == alm_pkg::ST_EXEC) && (count_reg < CAP_W), free_reg != '0, "free chain empty below capacity")
    `ALM_CHECK_NOW(a_empty_head, state_reg == alm_pkg::ST_IDLE, (count_reg == '0) == (head_reg == '0), "head and count disagree")
    `ALM_CHECK_NEXT(a_accept_exec, req_accept, state_reg == alm_pkg::ST_EXEC, "accepted request not executed")

endmodule

`default_nettype wire

// ----- hdl/alm_slot_store.sv -----
// Slot store: next links, previous links with in-use flags, and slot data.
`timescale 1ns / 1ps
`default_nettype none

module alm_slot_store #(
    parameter int CAPACITY  = 64,
    parameter int DATA_BITS = 32,
    localparam int NSLOTS    = CAPACITY + 1,
    localparam int SLOT_BITS = $clog2(NSLOTS)
) (
    input  wire                       clk,
    input  alm_pkg::store_we_t        we,
    input  wire [SLOT_BITS-1:0]       next_waddr,
    input  wire [SLOT_BITS-1:0]       next_wdata,
    input  wire [SLOT_BITS-1:0]       link_waddr,
    input  wire [SLOT_BITS:0]         link_wdata,
    input  wire [SLOT_BITS-1:0]       data_waddr,
    input  wire [DATA_BITS-1:0]       data_wdata,
    input  wire [SLOT_BITS-1:0]       pos_raddr,
    input  wire [SLOT_BITS-1:0]       free_raddr,
    output logic [SLOT_BITS-1:0]      pos_next,
    output logic [SLOT_BITS:0]        pos_link,
    output logic [SLOT_BITS-1:0]      free_next
);

    // next_mem: forward link; link_mem: {in use, backward link}
    logic [SLOT_BITS-1:0] next_mem [NSLOTS];
    logic [SLOT_BITS:0]   link_mem [NSLOTS];
    logic [DATA_BITS-1:0] data_mem [NSLOTS];

    // Forward links: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        pos_next  <= next_mem[pos_raddr];
        free_next <= next_mem[free_raddr];
    end

    // Backward links and in-use flags
    always_ff @(posedge clk)
    begin
        if (we.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        pos_link <= link_mem[pos_raddr];
    end

    // Slot payload, write only
    always_ff @(posedge clk)
    begin
        if (we.data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
    end

endmodule

`default_nettype wire
